>>> sv/rti_pkg.sv
package rti_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int THR_BITS   = 16;
  localparam int DIST_BITS  = COORD_BITS - 1;
  localparam int ADDR_BITS  = 5;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_PAR_THR  = 3'd6,
    REG_MIN_DIST = 3'd7
  } reg_idx_t;

  typedef logic [2:0][COORD_BITS-1:0] vec_t;

  typedef struct packed {
    vec_t va;
    vec_t vb;
    vec_t vc;
    vec_t nrm;
  } tri_t;

  typedef struct packed {
    logic                 miss;
    logic [DIST_BITS-1:0] tsat;
    vec_t                 pt;
  } res_t;

endpackage

>>> sv/ray_triangle_intersect.sv
// Ray/triangle intersection, plane test then edge test, in signed Q16.16.
// Load the ray (origin, direction) and the two thresholds over the APB port
// while no triangle is in flight, then issue one triangle per cycle with
// start; busy is always low. Each triangle gives exactly one result word,
// shown for one cycle with done, in issue order. The receiver cannot stall
// the block: capture every done cycle. The pipeline holds the restoring
// divider for t, one quotient bit per stage over 31 stages, plus the multiply
// stages of the plane and edge tests. On a miss, distance and point are zero.
module ray_triangle_intersect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rti_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            va_x,
  input  logic signed [31:0]            va_y,
  input  logic signed [31:0]            va_z,
  input  logic signed [31:0]            vb_x,
  input  logic signed [31:0]            vb_y,
  input  logic signed [31:0]            vb_z,
  input  logic signed [31:0]            vc_x,
  input  logic signed [31:0]            vc_y,
  input  logic signed [31:0]            vc_z,
  input  logic signed [31:0]            norm_x,
  input  logic signed [31:0]            norm_y,
  input  logic signed [31:0]            norm_z,
  output logic                          done,
  output logic                          hit,
  output logic [30:0]                   distance,
  output logic signed [31:0]            point_x,
  output logic signed [31:0]            point_y,
  output logic signed [31:0]            point_z
);
  import rti_pkg::*;

  localparam int DIV_STAGES = DIST_BITS;

  // configuration
  vec_t                origin;
  vec_t                dir;
  logic [THR_BITS-1:0] par_thr;
  logic [THR_BITS-1:0] min_dist;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin   <= '0;
      dir      <= {32'(1) << FRAC_BITS, 64'd0};
      par_thr  <= 16'd1;
      min_dist <= 16'd33;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_ORIGIN_X: origin[0] <= pwdata;
        REG_ORIGIN_Y: origin[1] <= pwdata;
        REG_ORIGIN_Z: origin[2] <= pwdata;
        REG_DIR_X:    dir[0]    <= pwdata;
        REG_DIR_Y:    dir[1]    <= pwdata;
        REG_DIR_Z:    dir[2]    <= pwdata;
        REG_PAR_THR:  par_thr   <= pwdata[THR_BITS-1:0];
        REG_MIN_DIST: min_dist  <= pwdata[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_ORIGIN_X: prdata = origin[0];
      REG_ORIGIN_Y: prdata = origin[1];
      REG_ORIGIN_Z: prdata = origin[2];
      REG_DIR_X:    prdata = dir[0];
      REG_DIR_Y:    prdata = dir[1];
      REG_DIR_Z:    prdata = dir[2];
      REG_PAR_THR:  prdata = {16'd0, par_thr};
      REG_MIN_DIST: prdata = {16'd0, min_dist};
      default:      prdata = '0;
    endcase
  end

  // stage 1: capture triangle, va - origin
  logic               v1;
  tri_t               t1;
  logic signed [32:0] d0_1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
  end

  always_ff @(posedge clk) begin
    t1.va  <= {va_z, va_y, va_x};
    t1.vb  <= {vb_z, vb_y, vb_x};
    t1.vc  <= {vc_z, vc_y, vc_x};
    t1.nrm <= {norm_z, norm_y, norm_x};
    d0_1[0] <= $signed({va_x[31], va_x}) - $signed({origin[0][31], origin[0]});
    d0_1[1] <= $signed({va_y[31], va_y}) - $signed({origin[1][31], origin[1]});
    d0_1[2] <= $signed({va_z[31], va_z}) - $signed({origin[2][31], origin[2]});
  end

  // stage 2: dot product terms
  logic               v2;
  tri_t               t2;
  logic signed [63:0] pd2 [3];
  logic signed [64:0] pn2 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    t2 <= t1;
    for (int i = 0; i < 3; i++) begin
      pd2[i] <= $signed(t1.nrm[i]) * $signed(dir[i]);
      pn2[i] <= d0_1[i] * $signed(t1.nrm[i]);
    end
  end

  // stage 3: sums
  logic               v3;
  tri_t               t3;
  logic signed [65:0] den3;
  logic signed [66:0] num3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    t3   <= t2;
    den3 <= 66'(pd2[0]) + 66'(pd2[1]) + 66'(pd2[2]);
    num3 <= 67'(pn2[0]) + 67'(pn2[1]) + 67'(pn2[2]);
  end

  // stage 4: make denominator positive, parallel and behind-origin checks
  logic               v4;
  tri_t               t4;
  logic [64:0]        den4;
  logic signed [66:0] num4;
  logic               miss4;
  logic signed [65:0] den_neg;
  logic [64:0]        den_abs;
  logic signed [66:0] num_adj;

  always_comb begin
    den_neg = -den3;
    den_abs = den3[65] ? den_neg[64:0] : den3[64:0];
    num_adj = den3[65] ? -num3 : num3;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    t4    <= t3;
    den4  <= den_abs;
    num4  <= num_adj;
    miss4 <= (den_abs == '0) || (den_abs < {33'd0, par_thr, 16'd0}) || num_adj[66];
  end

  // stage 5: scale numerator, detect quotient overflow
  logic        dv_v    [DIV_STAGES+1];
  tri_t        dv_t    [DIV_STAGES+1];
  logic [64:0] dv_den  [DIV_STAGES+1];
  logic [80:0] dv_rem  [DIV_STAGES+1];
  logic [30:0] dv_quo  [DIV_STAGES+1];
  logic        dv_sat  [DIV_STAGES+1];
  logic        dv_miss [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= v4;
  end

  always_ff @(posedge clk) begin
    dv_t[0]    <= t4;
    dv_den[0]  <= den4;
    dv_rem[0]  <= {num4[64:0], 16'd0};
    dv_quo[0]  <= '0;
    dv_sat[0]  <= {15'd0, num4[64:0], 16'd0} >= {den4, 31'd0};
    dv_miss[0] <= miss4;
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int B = DIV_STAGES - 1 - k;
    logic [95:0] sub;
    logic        ge;

    always_comb begin
      sub = {31'd0, dv_den[k]} << B;
      ge  = {15'd0, dv_rem[k]} >= sub;
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else     dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      dv_t[k+1]    <= dv_t[k];
      dv_den[k+1]  <= dv_den[k];
      dv_rem[k+1]  <= ge ? dv_rem[k] - sub[80:0] : dv_rem[k];
      dv_quo[k+1]  <= {dv_quo[k][29:0], ge};
      dv_sat[k+1]  <= dv_sat[k];
      dv_miss[k+1] <= dv_miss[k];
    end
  end

  // t saturation and minimum distance
  logic        vt;
  tri_t        tt;
  logic [30:0] tsat_t;
  logic        miss_t;

  always_ff @(posedge clk) begin
    if (rst) vt <= 1'b0;
    else     vt <= dv_v[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    tt     <= dv_t[DIV_STAGES];
    tsat_t <= dv_sat[DIV_STAGES] ? '1 : dv_quo[DIV_STAGES];
    miss_t <= dv_miss[DIV_STAGES] ||
              (!dv_sat[DIV_STAGES] && (dv_quo[DIV_STAGES] < {15'd0, min_dist}));
  end

  // dir * t
  logic               vm;
  tri_t               tm;
  logic [30:0]        tsat_m;
  logic               miss_m;
  logic signed [63:0] pm [3];

  always_ff @(posedge clk) begin
    if (rst) vm <= 1'b0;
    else     vm <= vt;
  end

  always_ff @(posedge clk) begin
    tm     <= tt;
    tsat_m <= tsat_t;
    miss_m <= miss_t;
    for (int i = 0; i < 3; i++) begin
      pm[i] <= $signed(dir[i]) * $signed({1'b0, tsat_t});
    end
  end

  // hit point, floor and clamp
  logic               va_p;
  tri_t               ta;
  res_t               ra;
  logic signed [64:0] psum [3];
  vec_t               pclamp;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = $signed({{17{origin[i][31]}}, origin[i], 16'd0}) +
                $signed({pm[i][63], pm[i]});
      if (psum[i][64:47] == '0 || psum[i][64:47] == '1) begin
        pclamp[i] = psum[i][47:16];
      end else if (psum[i][64]) begin
        pclamp[i] = {1'b1, 31'd0};
      end else begin
        pclamp[i] = {1'b0, {31{1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) va_p <= 1'b0;
    else     va_p <= vm;
  end

  always_ff @(posedge clk) begin
    ta      <= tm;
    ra.miss <= miss_m;
    ra.tsat <= tsat_m;
    ra.pt   <= pclamp;
  end

  // edge test e1: edge and hit vectors
  logic               ve [5];
  res_t               re [5];
  vec_t               ne [3];
  logic signed [32:0] ee [3][3];
  logic signed [32:0] he [3][3];
  vec_t               ep [3];
  vec_t               eq [3];

  assign ep[0] = ta.va;
  assign ep[1] = ta.vb;
  assign ep[2] = ta.vc;
  assign eq[0] = ta.vb;
  assign eq[1] = ta.vc;
  assign eq[2] = ta.va;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 5; s++) ve[s] <= 1'b0;
    end else begin
      ve[0] <= va_p;
      for (int s = 1; s < 5; s++) ve[s] <= ve[s-1];
    end
  end

  always_ff @(posedge clk) begin
    re[0] <= ra;
    ne[0] <= ta.nrm;
    for (int s = 1; s < 5; s++) re[s] <= re[s-1];
    for (int s = 1; s < 3; s++) ne[s] <= ne[s-1];
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        ee[j][i] <= $signed({eq[j][i][31], eq[j][i]}) - $signed({ep[j][i][31], ep[j][i]});
        he[j][i] <= $signed({ra.pt[i][31], ra.pt[i]}) - $signed({ep[j][i][31], ep[j][i]});
      end
    end
  end

  // e2: cross product terms
  logic signed [65:0] xm [3][6];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      xm[j][0] <= ee[j][1] * he[j][2];
      xm[j][1] <= ee[j][2] * he[j][1];
      xm[j][2] <= ee[j][2] * he[j][0];
      xm[j][3] <= ee[j][0] * he[j][2];
      xm[j][4] <= ee[j][0] * he[j][1];
      xm[j][5] <= ee[j][1] * he[j][0];
    end
  end

  // e3: cross product
  logic signed [66:0] xc [3][3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        xc[j][i] <= 67'(xm[j][2*i]) - 67'(xm[j][2*i+1]);
      end
    end
  end

  // e4: cross dot normal, split in low and high partial products
  logic signed [66:0] pl [3][3];
  logic signed [64:0] ph [3][3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        pl[j][i] <= $signed({1'b0, xc[j][i][33:0]}) * $signed(ne[2][i]);
        ph[j][i] <= $signed(xc[j][i][66:34]) * $signed(ne[2][i]);
      end
    end
  end

  // e5: full products
  logic signed [99:0] pf [3][3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        pf[j][i] <= 100'($signed({ph[j][i], 34'd0})) + 100'(pl[j][i]);
      end
    end
  end

  // sign test and result word
  logic signed [101:0] side [3];
  logic                all_pos;
  logic                all_neg;
  logic                hit_next;

  always_comb begin
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int j = 0; j < 3; j++) begin
      side[j] = 102'(pf[j][0]) + 102'(pf[j][1]) + 102'(pf[j][2]);
      if (side[j][101] || side[j] == '0) all_pos = 1'b0;
      if (!side[j][101]) all_neg = 1'b0;
    end
    hit_next = !re[4].miss && (all_pos || all_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= ve[4];
  end

  always_ff @(posedge clk) begin
    hit      <= hit_next;
    distance <= hit_next ? re[4].tsat : '0;
    point_x  <= hit_next ? re[4].pt[0] : '0;
    point_y  <= hit_next ? re[4].pt[1] : '0;
    point_z  <= hit_next ? re[4].pt[2] : '0;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rti_pkg::*;

  typedef logic signed [255:0] w_t;
  typedef struct packed {
    w_t x;
    w_t y;
    w_t z;
  } wv_t;
  typedef logic [11:0][31:0] tri_word_t;
  typedef struct packed {
    logic        hit;
    logic [30:0] tval;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } hit_rec_t;

  localparam int LATENCY = 45;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  tri_word_t tri_in = '0;
  logic done, hit;
  logic [30:0] distance;
  logic signed [31:0] point_x, point_y, point_z;

  ray_triangle_intersect u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .va_x(tri_in[0]), .va_y(tri_in[1]), .va_z(tri_in[2]),
    .vb_x(tri_in[3]), .vb_y(tri_in[4]), .vb_z(tri_in[5]),
    .vc_x(tri_in[6]), .vc_y(tri_in[7]), .vc_z(tri_in[8]),
    .norm_x(tri_in[9]), .norm_y(tri_in[10]), .norm_z(tri_in[11]),
    .done(done), .hit(hit), .distance(distance),
    .point_x(point_x), .point_y(point_y), .point_z(point_z)
  );

  always #2 clk = ~clk;

  // ray and thresholds as the block holds them
  logic [31:0] ray_org[3];
  logic [31:0] ray_dir[3];
  logic [15:0] par_thr;
  logic [15:0] min_dist;

  tri_word_t pending_tris[$];
  hit_rec_t  expected_hits[$];
  int errors = 0;
  int n_results = 0;
  int n_hits = 0;
  int cycles = 0;

  function automatic w_t sx(logic [31:0] v);
    w_t r;
    r = $signed(v);
    return r;
  endfunction

  function automatic w_t clamp_coord(w_t v);
    if (v < sx(32'h80000000)) return sx(32'h80000000);
    if (v > sx(32'h7fffffff)) return sx(32'h7fffffff);
    return v;
  endfunction

  function automatic w_t edge_side(wv_t p, wv_t q, wv_t pt, wv_t n);
    wv_t e, h;
    w_t cx, cy, cz;
    e.x = q.x - p.x; e.y = q.y - p.y; e.z = q.z - p.z;
    h.x = pt.x - p.x; h.y = pt.y - p.y; h.z = pt.z - p.z;
    cx = e.y * h.z - e.z * h.y;
    cy = e.z * h.x - e.x * h.z;
    cz = e.x * h.y - e.y * h.x;
    return cx * n.x + cy * n.y + cz * n.z;
  endfunction

  function automatic hit_rec_t predict_hit(tri_word_t f);
    wv_t a, b, c, n, o, d, p;
    w_t den, num, lim, tq, tw, s1, s2, s3;
    logic [30:0] ts;
    hit_rec_t r;
    r = '0;
    a.x = sx(f[0]); a.y = sx(f[1]); a.z = sx(f[2]);
    b.x = sx(f[3]); b.y = sx(f[4]); b.z = sx(f[5]);
    c.x = sx(f[6]); c.y = sx(f[7]); c.z = sx(f[8]);
    n.x = sx(f[9]); n.y = sx(f[10]); n.z = sx(f[11]);
    o.x = sx(ray_org[0]); o.y = sx(ray_org[1]); o.z = sx(ray_org[2]);
    d.x = sx(ray_dir[0]); d.y = sx(ray_dir[1]); d.z = sx(ray_dir[2]);
    den = n.x * d.x + n.y * d.y + n.z * d.z;
    num = (a.x - o.x) * n.x + (a.y - o.y) * n.y + (a.z - o.z) * n.z;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    lim = {240'b0, par_thr};
    lim = lim <<< FRAC_BITS;
    if (den == 0 || den < lim) return r;
    num = num <<< FRAC_BITS;
    lim = {240'b0, min_dist};
    if (num < lim * den) return r;
    tq = num / den;
    if (tq > sx(32'h7fffffff)) ts = '1;
    else ts = tq[30:0];
    tw = {225'b0, ts};
    p.x = clamp_coord(((o.x <<< FRAC_BITS) + d.x * tw) >>> FRAC_BITS);
    p.y = clamp_coord(((o.y <<< FRAC_BITS) + d.y * tw) >>> FRAC_BITS);
    p.z = clamp_coord(((o.z <<< FRAC_BITS) + d.z * tw) >>> FRAC_BITS);
    s1 = edge_side(a, b, p, n);
    s2 = edge_side(b, c, p, n);
    s3 = edge_side(c, a, p, n);
    if ((s1 > 0 && s2 > 0 && s3 > 0) || (s1 < 0 && s2 < 0 && s3 < 0)) begin
      r.hit = 1'b1;
      r.tval = ts;
      r.px = p.x[31:0];
      r.py = p.y[31:0];
      r.pz = p.z[31:0];
    end
    return r;
  endfunction

  // driver: bursts of triangles with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_tris.size() > 0) begin
      tri_in <= pending_tris.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_rec_t exp_r;
    cycles <= cycles + 1;
    if (!rst && start && !busy) expected_hits.push_back(predict_hit(tri_in));
    if (!rst && done) begin
      n_results <= n_results + 1;
      if (hit) n_hits <= n_hits + 1;
      if (expected_hits.size() == 0) begin
        $display("%0t: result word with nothing expected (hit=%0b)", $time, hit);
        errors <= errors + 1;
      end else begin
        exp_r = expected_hits.pop_front();
        if (hit !== exp_r.hit || distance !== exp_r.tval || point_x !== exp_r.px ||
            point_y !== exp_r.py || point_z !== exp_r.pz) begin
          $display("%0t: mismatch expected hit=%0b t=%h p=(%h %h %h)", $time,
                   exp_r.hit, exp_r.tval, exp_r.px, exp_r.py, exp_r.pz);
          $display("%0t:          actual   hit=%0b t=%h p=(%h %h %h)", $time,
                   hit, distance, point_x, point_y, point_z);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = ADDR_BITS'(int'(idx) * 4); pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ORIGIN_X: ray_org[0] = val;
      REG_ORIGIN_Y: ray_org[1] = val;
      REG_ORIGIN_Z: ray_org[2] = val;
      REG_DIR_X:    ray_dir[0] = val;
      REG_DIR_Y:    ray_dir[1] = val;
      REG_DIR_Z:    ray_dir[2] = val;
      REG_PAR_THR:  par_thr = val[15:0];
      default:      min_dist = val[15:0];
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [15:0] thr, md);
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_ORIGIN_Z, oz);
    reg_write(REG_DIR_X, dx);
    reg_write(REG_DIR_Y, dy);
    reg_write(REG_DIR_Z, dz);
    reg_write(REG_PAR_THR, {16'b0, thr});
    reg_write(REG_MIN_DIST, {16'b0, md});
  endtask

  function automatic logic [31:0] rand_signed(int bits);
    logic [31:0] v;
    v = $urandom;
    v = $signed(v) >>> (32 - bits);
    return v;
  endfunction

  // triangle around a point on the current ray, normal from the edge cross product
  function automatic tri_word_t aimed_tri();
    tri_word_t f;
    longint cen[3], off[3][3], e1[3], e2[3], nn[3];
    longint tt;
    tt = $urandom_range(0, 16 << 16);
    for (int i = 0; i < 3; i++) begin
      cen[i] = longint'($signed(ray_org[i])) + ((longint'($signed(ray_dir[i])) * tt) >>> 16);
      for (int k = 0; k < 3; k++) off[k][i] = longint'($signed(rand_signed(20)));
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = off[1][i] - off[0][i];
      e2[i] = off[2][i] - off[0][i];
    end
    nn[0] = (e1[1] * e2[2] - e1[2] * e2[1]) >>> 10;
    nn[1] = (e1[2] * e2[0] - e1[0] * e2[2]) >>> 10;
    nn[2] = (e1[0] * e2[1] - e1[1] * e2[0]) >>> 10;
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) f[3 * k + i] = 32'(cen[i] + off[k][i]);
    for (int i = 0; i < 3; i++) f[9 + i] = 32'(nn[i]);
    return f;
  endfunction

  function automatic tri_word_t noise_tri();
    tri_word_t f;
    for (int i = 0; i < 12; i++) f[i] = $urandom;
    return f;
  endfunction

  task automatic queue_random(int count);
    tri_word_t f;
    int sel;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        f = aimed_tri();
      end else if (sel < 85) begin
        f = noise_tri();
      end else begin
        // broken: one word replaced with junk
        f = aimed_tri();
        f[$urandom_range(0, 11)] = $urandom;
      end
      pending_tris.push_back(f);
    end
  endtask

  task automatic drain();
    while (pending_tris.size() > 0 || expected_hits.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic tri_word_t make_tri(logic [31:0] a[3], b[3], c[3], n[3]);
    tri_word_t f;
    for (int i = 0; i < 3; i++) begin
      f[i] = a[i]; f[3 + i] = b[i]; f[6 + i] = c[i]; f[9 + i] = n[i];
    end
    return f;
  endfunction

  task automatic queue_directed();
    tri_word_t f;
    logic [31:0] one;
    one = 32'h0001_0000;
    // everything zero: zero denominator
    pending_tris.push_back('0);
    // all most negative, all most positive, all words minus one
    pending_tris.push_back({12{32'h8000_0000}});
    pending_tris.push_back({12{32'h7fff_ffff}});
    pending_tris.push_back({12{32'hffff_ffff}});
    // triangle in z = 2 facing the ray, both windings
    f = make_tri('{-one, -one, 2 * one}, '{one, -one, 2 * one}, '{0, one, 2 * one},
                 '{0, 0, one});
    pending_tris.push_back(f);
    f = make_tri('{0, one, 2 * one}, '{one, -one, 2 * one}, '{-one, -one, 2 * one},
                 '{0, 0, one});
    pending_tris.push_back(f);
    // negated normal
    f[11] = -one;
    pending_tris.push_back(f);
    // plane behind the start point
    f = make_tri('{-one, -one, -2 * one}, '{one, -one, -2 * one}, '{0, one, -2 * one},
                 '{0, 0, one});
    pending_tris.push_back(f);
    // normal perpendicular to the ray: parallel
    f[11] = 0; f[9] = one;
    pending_tris.push_back(f);
    // zero normal: zero denominator
    f = make_tri('{-one, -one, one}, '{one, -one, one}, '{0, one, one}, '{0, 0, 0});
    pending_tris.push_back(f);
    // plane just at the start point: below minimum distance
    f = make_tri('{-one, -one, 1}, '{one, -one, 1}, '{0, one, 1}, '{0, 0, one});
    pending_tris.push_back(f);
    // far plane: large t
    f = make_tri('{-one, -one, 32'h7fff_0000}, '{one, -one, 32'h7fff_0000},
                 '{0, one, 32'h7fff_0000}, '{0, 0, 32'h0000_0100});
    pending_tris.push_back(f);
    // degenerate triangle: all vertices equal
    f = make_tri('{0, 0, 2 * one}, '{0, 0, 2 * one}, '{0, 0, 2 * one}, '{0, 0, one});
    pending_tris.push_back(f);
    // ray through a vertex: edge products zero
    f = make_tri('{0, 0, 2 * one}, '{one, 0, 2 * one}, '{0, one, 2 * one}, '{0, 0, one});
    pending_tris.push_back(f);
    // ray outside the triangle
    f = make_tri('{one, one, 2 * one}, '{3 * one, one, 2 * one}, '{2 * one, 3 * one, 2 * one},
                 '{0, 0, one});
    pending_tris.push_back(f);
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, 32'h0001_0000};
    par_thr = 16'd1;
    min_dist = 16'd33;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset ray first
    queue_directed();
    queue_random(150);
    drain();

    // zero thresholds: zero denominator still misses
    set_ray(0, 0, 0, 0, 0, 32'h0001_0000, 16'd0, 16'd0);
    queue_directed();
    queue_random(100);
    drain();

    // largest thresholds
    set_ray(0, 0, 0, 0, 0, 32'h0001_0000, 16'hffff, 16'hffff);
    queue_directed();
    queue_random(60);
    drain();

    // extreme ray words
    set_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd1, 16'd1);
    queue_directed();
    queue_random(60);
    drain();

    // random short rays
    repeat (6) begin
      set_ray(rand_signed(23), rand_signed(23), rand_signed(23),
              rand_signed(18), rand_signed(18), rand_signed(18),
              16'($urandom_range(0, 1023)), 16'($urandom_range(0, 4000)));
      queue_random(90);
      drain();
    end

    $display("%0d triangles checked against %0d ray settings, %0d of them hits",
             n_results, 10, n_hits);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/rti_pkg.sv
sv/ray_triangle_intersect.sv
tb/sv/tb.sv
